// File: rtl/mcpg_pkg.sv
// ----------------------------------------------------------------------------
// mcpg_pkg
// Shared widths, types and command codes for the midpoint circle point
// generator.
// ----------------------------------------------------------------------------
`default_nettype none

package mcpg_pkg;

    localparam int RADIUS_BITS  = 14;
    localparam int COORD_BITS   = 16;
    localparam int CENTER_BITS  = COORD_BITS - 1;
    localparam int DEC_BITS     = RADIUS_BITS + 4;
    // next x / next y need one bit of headroom plus a sign bit
    localparam int STEP_BITS    = RADIUS_BITS + 2;
    localparam int PTS_PER_STEP = 8;
    localparam int IDX_BITS     = $clog2(PTS_PER_STEP);

    typedef enum logic {
        CMD_START   = 1'b0,
        CMD_ADVANCE = 1'b1
    } cmd_t;

    typedef logic [RADIUS_BITS-1:0]        offset_t;
    typedef logic signed [CENTER_BITS-1:0] center_t;
    typedef logic signed [COORD_BITS-1:0]  coord_t;
    typedef logic signed [DEC_BITS-1:0]    dec_t;
    typedef logic [IDX_BITS-1:0]           pt_idx_t;

    // One octant step handed from the stepper to the point emitter
    typedef struct packed {
        offset_t x;
        offset_t y;
        center_t cx;
        center_t cy;
        logic    done;
    } step_snap_t;

    localparam pt_idx_t LAST_IDX = pt_idx_t'(PTS_PER_STEP - 1);

endpackage

`default_nettype wire

// File: rtl/mcpg_step.sv
// ----------------------------------------------------------------------------
// mcpg_step
// Circle state and midpoint decision update; captures each step's octant
// point and center into a one-entry holding register for the emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module mcpg_step
    import mcpg_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [0:0] s_cmd,
    input  wire center_t    s_center_x,
    input  wire center_t    s_center_y,
    input  wire offset_t    s_radius,
    output logic            snap_valid,
    input  wire logic       snap_take,
    output step_snap_t      snap
);

    offset_t    octant_x_reg, octant_x_next;
    offset_t    octant_y_reg, octant_y_next;
    dec_t       decision_reg, decision_next;
    center_t    origin_x_reg, origin_x_next;
    center_t    origin_y_reg, origin_y_next;
    logic       active_reg,   active_next;
    logic       pend_valid_reg, pend_valid_next;
    step_snap_t pend_reg,       pend_next;

    logic                        accept;
    logic                        start;
    logic                        produce;
    offset_t                     x_cur;
    offset_t                     y_cur;
    dec_t                        d_cur;
    center_t                     cx_cur;
    center_t                     cy_cur;
    logic                        d_pos;
    logic signed [STEP_BITS-1:0] nx;
    logic signed [STEP_BITS-1:0] ny;
    logic signed [STEP_BITS-1:0] term;
    dec_t                        nd;
    logic                        done;

    assign s_ready    = !pend_valid_reg || snap_take;
    assign accept     = s_valid && s_ready;
    assign snap_valid = pend_valid_reg;
    assign snap       = pend_reg;

    always_comb begin
        start   = (cmd_t'(s_cmd) == CMD_START);
        produce = start || active_reg;
        x_cur   = start ? s_radius : octant_x_reg;
        y_cur   = start ? '0 : octant_y_reg;
        d_cur   = start ? (dec_t'(1) - dec_t'(s_radius)) : decision_reg;
        cx_cur  = start ? s_center_x : origin_x_reg;
        cy_cur  = start ? s_center_y : origin_y_reg;

        d_pos = !d_cur[DEC_BITS-1] && (d_cur != '0);
        ny    = STEP_BITS'(y_cur) + STEP_BITS'(1);
        nx    = STEP_BITS'(x_cur) - (d_pos ? STEP_BITS'(1) : STEP_BITS'(0));
        term  = d_pos ? (ny - nx) : ny;
        nd    = d_cur + (dec_t'(term) <<< 1) + dec_t'(1);
        done  = ny > nx;
    end

    always_comb begin
        octant_x_next   = octant_x_reg;
        octant_y_next   = octant_y_reg;
        decision_next   = decision_reg;
        origin_x_next   = origin_x_reg;
        origin_y_next   = origin_y_reg;
        active_next     = active_reg;
        pend_valid_next = pend_valid_reg && !snap_take;
        pend_next       = pend_reg;
        if (accept && produce) begin
            octant_x_next   = nx[RADIUS_BITS-1:0];
            octant_y_next   = ny[RADIUS_BITS-1:0];
            decision_next   = nd;
            origin_x_next   = cx_cur;
            origin_y_next   = cy_cur;
            active_next     = !done;
            pend_valid_next = 1'b1;
            pend_next.x     = x_cur;
            pend_next.y     = y_cur;
            pend_next.cx    = cx_cur;
            pend_next.cy    = cy_cur;
            pend_next.done  = done;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            octant_x_reg   <= '0;
            octant_y_reg   <= '0;
            decision_reg   <= '0;
            origin_x_reg   <= '0;
            origin_y_reg   <= '0;
            active_reg     <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            octant_x_reg   <= octant_x_next;
            octant_y_reg   <= octant_y_next;
            decision_reg   <= decision_next;
            origin_x_reg   <= origin_x_next;
            origin_y_reg   <= origin_y_next;
            active_reg     <= active_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_reg <= pend_next;
    end

endmodule

`default_nettype wire

// File: rtl/mcpg_emit.sv
// ----------------------------------------------------------------------------
// mcpg_emit
// Walks the eight symmetric points of one step and drives the registered
// result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module mcpg_emit
    import mcpg_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       snap_valid,
    output logic            snap_take,
    input  wire step_snap_t snap,
    output logic            m_valid,
    input  wire logic       m_ready,
    output coord_t          m_point_x,
    output coord_t          m_point_y,
    output logic            m_step_last,
    output logic            m_circle_done
);

    step_snap_t cur_reg,   cur_next;
    logic       busy_reg,  busy_next;
    pt_idx_t    idx_reg,   idx_next;
    logic       m_valid_reg, m_valid_next;
    coord_t     px_reg,    px_next;
    coord_t     py_reg,    py_next;
    logic       last_reg,  last_next;
    logic       done_reg,  done_next;

    logic    adv;
    logic    at_last;
    offset_t a_off;
    offset_t b_off;
    coord_t  cx_w;
    coord_t  cy_w;

    assign m_valid       = m_valid_reg;
    assign m_point_x     = px_reg;
    assign m_point_y     = py_reg;
    assign m_step_last   = last_reg;
    assign m_circle_done = done_reg;

    assign adv       = busy_reg && (!m_valid_reg || m_ready);
    assign at_last   = (idx_reg == LAST_IDX);
    assign snap_take = snap_valid && (!busy_reg || (adv && at_last));

    // idx[2] swaps x/y, idx[1] negates the x term, idx[0] the y term
    always_comb begin
        a_off = idx_reg[2] ? cur_reg.y : cur_reg.x;
        b_off = idx_reg[2] ? cur_reg.x : cur_reg.y;
        cx_w  = coord_t'(cur_reg.cx);
        cy_w  = coord_t'(cur_reg.cy);
    end

    always_comb begin
        cur_next     = cur_reg;
        busy_next    = busy_reg;
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg && !m_ready;
        px_next      = px_reg;
        py_next      = py_reg;
        last_next    = last_reg;
        done_next    = done_reg;
        if (adv) begin
            m_valid_next = 1'b1;
            px_next      = idx_reg[1] ? (cx_w - coord_t'(a_off)) : (cx_w + coord_t'(a_off));
            py_next      = idx_reg[0] ? (cy_w - coord_t'(b_off)) : (cy_w + coord_t'(b_off));
            last_next    = at_last;
            done_next    = at_last && cur_reg.done;
            idx_next     = idx_reg + pt_idx_t'(1);
            if (at_last) begin
                busy_next = 1'b0;
            end
        end
        if (snap_take) begin
            cur_next  = snap;
            busy_next = 1'b1;
            idx_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg  <= cur_next;
        px_reg   <= px_next;
        py_reg   <= py_next;
        last_reg <= last_next;
        done_reg <= done_next;
    end

endmodule

`default_nettype wire

// File: rtl/midpoint_circle_point_generator_unit.sv
// ----------------------------------------------------------------------------
// midpoint_circle_point_generator_unit
// Midpoint circle rasterizer with eight-way symmetry, valid/ready channels.
// ----------------------------------------------------------------------------
// A start beat (cmd 0) loads center and radius; it and every advance beat
// (cmd 1) produce eight result beats, the symmetric points of the current
// octant point, the eighth flagged step_last and, on the final step of the
// circle, circle_done. An advance with no circle running is taken and
// produces nothing. Results leave at one beat per cycle while m_ready is
// high, set by the one-point-per-cycle result register, and stall while
// it is low. An accepted beat passes the holding register, the emitter's
// step register and the result register; one step waits in the holding
// register while the previous one drains, so input and output overlap.
`default_nettype none

module midpoint_circle_point_generator_unit
    import mcpg_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [0:0] s_cmd,
    input  wire center_t    s_center_x,
    input  wire center_t    s_center_y,
    input  wire offset_t    s_radius,
    output logic            m_valid,
    input  wire logic       m_ready,
    output coord_t          m_point_x,
    output coord_t          m_point_y,
    output logic            m_step_last,
    output logic            m_circle_done
);

    logic       snap_valid;
    logic       snap_take;
    step_snap_t snap;

    mcpg_step u_step (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_cmd      (s_cmd),
        .s_center_x (s_center_x),
        .s_center_y (s_center_y),
        .s_radius   (s_radius),
        .snap_valid (snap_valid),
        .snap_take  (snap_take),
        .snap       (snap)
    );

    mcpg_emit u_emit (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .snap_valid    (snap_valid),
        .snap_take     (snap_take),
        .snap          (snap),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_point_x     (m_point_x),
        .m_point_y     (m_point_y),
        .m_step_last   (m_step_last),
        .m_circle_done (m_circle_done)
    );

    // done only rides on the closing beat of a step
    a_done_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_circle_done |-> m_step_last)
        else $error("circle_done without step_last");

    // the eight beats of a step leave back to back once the sink takes them
    a_step_burst: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_step_last |=> m_valid)
        else $error("gap inside a step");

    // input stalls only while the holding register is full and not being drained
    a_hold_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> snap_valid && !snap_take)
        else $error("input stalled with free holding register");

endmodule

`default_nettype wire

// File: tb/sv/tb_circle_pkg.sv
// ----------------------------------------------------------------------------
// tb_circle_pkg
// Point predictor and scoreboard for the midpoint circle point generator:
// tracks the octant walk per accepted input beat and checks every point.
// ----------------------------------------------------------------------------
package tb_circle_pkg;

    import mcpg_pkg::*;

    class circle_scoreboard;

        typedef struct {
            coord_t px;
            coord_t py;
            logic   last;
            logic   done;
        } circle_point_t;

        circle_point_t pending_points[$];

        // mirror of the octant walk
        offset_t walk_x;
        offset_t walk_y;
        dec_t    walk_dec;
        center_t org_x;
        center_t org_y;
        bit      active;

        int errors;
        int reported;
        int checked;
        int circles_done;

        function new();
            walk_x   = '0;
            walk_y   = '0;
            walk_dec = '0;
            org_x    = '0;
            org_y    = '0;
            active   = 1'b0;
        endfunction

        function void push_point(int px, int py, bit last, bit done);
            circle_point_t p;
            p.px   = coord_t'(px);
            p.py   = coord_t'(py);
            p.last = last;
            p.done = done;
            pending_points.push_back(p);
        endfunction

        // Returns the number of points this beat produces (0 or 8).
        function int note_input(cmd_t cmd, center_t cx, center_t cy, offset_t r);
            int x, y, d, ox, oy, nx, ny, nd;
            bit fin;
            if (cmd == CMD_START) begin
                org_x    = cx;
                org_y    = cy;
                walk_x   = r;
                walk_y   = '0;
                walk_dec = dec_t'(1 - int'(r));
                active   = 1'b1;
            end else if (!active) begin
                return 0;
            end
            x  = int'(walk_x);
            y  = int'(walk_y);
            d  = walk_dec;
            ox = org_x;
            oy = org_y;
            ny = y + 1;
            nx = x;
            if (d <= 0) begin
                nd = d + 2 * ny + 1;
            end else begin
                nx = x - 1;
                nd = d + 2 * (ny - nx) + 1;
            end
            // x can go negative on a zero radius, compare as signed
            fin = (ny > nx);
            push_point(ox + x, oy + y, 0, 0);
            push_point(ox + x, oy - y, 0, 0);
            push_point(ox - x, oy + y, 0, 0);
            push_point(ox - x, oy - y, 0, 0);
            push_point(ox + y, oy + x, 0, 0);
            push_point(ox + y, oy - x, 0, 0);
            push_point(ox - y, oy + x, 0, 0);
            push_point(ox - y, oy - x, 1, fin);
            walk_x   = offset_t'(nx);
            walk_y   = offset_t'(ny);
            walk_dec = dec_t'(nd);
            if (fin) begin
                active = 1'b0;
                circles_done++;
            end
            return PTS_PER_STEP;
        endfunction

        function void check_result(coord_t px, coord_t py, logic last, logic done);
            circle_point_t p;
            checked++;
            if (pending_points.size() == 0) begin
                errors++;
                if (reported < 10) begin
                    reported++;
                    $display("ERROR: unexpected point (%0d,%0d) last %0b done %0b",
                             px, py, last, done);
                end
                return;
            end
            p = pending_points.pop_front();
            if (p.px !== px || p.py !== py || p.last !== last || p.done !== done) begin
                errors++;
                if (reported < 10) begin
                    reported++;
                    $display("ERROR: point %0d expected (%0d,%0d) last %0b done %0b, got (%0d,%0d) last %0b done %0b",
                             checked, p.px, p.py, p.last, p.done, px, py, last, done);
                end
            end
        endfunction

        function int pending();
            return pending_points.size();
        endfunction

        function void report_leftovers();
            if (pending_points.size() != 0) begin
                errors += pending_points.size();
                $display("ERROR: %0d expected points never arrived", pending_points.size());
            end
        endfunction

    endclass

endpackage

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for midpoint_circle_point_generator_unit: directed corner
// circles, then random start/advance sequences under varied back-pressure.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import mcpg_pkg::*;
    import tb_circle_pkg::*;

    localparam int RAND_ITEMS     = 380;
    localparam int STALL_LIMIT    = 4000;
    localparam int LONG_HOLD      = 120;
    localparam int END_PAUSE      = 16;

    logic    aclk          = 1'b0;
    logic    aresetn       = 1'b0;
    logic    s_valid       = 1'b0;
    logic    s_ready;
    logic    [0:0] s_cmd   = CMD_ADVANCE;
    center_t s_center_x    = '0;
    center_t s_center_y    = '0;
    offset_t s_radius      = '0;
    logic    m_valid;
    logic    m_ready       = 1'b0;
    coord_t  m_point_x;
    coord_t  m_point_y;
    logic    m_step_last;
    logic    m_circle_done;

    circle_scoreboard sb;

    int  tx_idle_pct = 17;
    int  rx_idle_pct = 83;
    bit  hold_go     = 1'b0;
    bit  hold_taken  = 1'b0;
    int  hold_left   = 0;
    int  stall_cycles = 0;

    int  beats_in;
    int  starts;
    int  advances;
    int  idle_advances;
    int  productive;

    midpoint_circle_point_generator_unit u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_center_x    (s_center_x),
        .s_center_y    (s_center_y),
        .s_radius      (s_radius),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_point_x     (m_point_x),
        .m_point_y     (m_point_y),
        .m_step_last   (m_step_last),
        .m_circle_done (m_circle_done)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // result side: check accepted beats, then pick next ready
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_point_x, m_point_y, m_step_last, m_circle_done);
        end
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (hold_go && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left  <= LONG_HOLD;
            m_ready    <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("ERROR: no beat moved for %0d cycles", STALL_LIMIT);
                $display("tb_top: done, errors");
                $finish;
            end
        end
    end

    function automatic center_t rand_center();
        return center_t'($urandom());
    endfunction

    // mostly small radii so circles finish; now and then the full range
    function automatic offset_t rand_radius();
        if ($urandom_range(0, 19) == 0) begin
            return offset_t'($urandom_range(0, 16383));
        end
        return offset_t'($urandom_range(0, 24));
    endfunction

    task automatic send_item(input cmd_t cmd, input center_t cx, input center_t cy,
                             input offset_t r);
        int n;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_cmd      <= cmd;
        s_center_x <= cx;
        s_center_y <= cy;
        s_radius   <= r;
        do @(posedge aclk); while (!s_ready);
        n = sb.note_input(cmd, cx, cy, r);
        beats_in++;
        if (cmd == CMD_START) begin
            starts++;
        end else if (n == 0) begin
            idle_advances++;
        end else begin
            advances++;
        end
        if (n != 0) begin
            productive++;
        end
    endtask

    task automatic send_advance();
        send_item(CMD_ADVANCE, rand_center(), rand_center(), offset_t'($urandom()));
    endtask

    // advance until the circle closes or the step budget runs out
    task automatic walk_circle(input int max_steps);
        int k;
        k = 0;
        while (sb.active && k < max_steps) begin
            send_advance();
            k++;
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) begin
            @(posedge aclk);
        end
    endtask

    initial begin
        int      kind;
        int      base;
        int      n;
        offset_t r;

        sb = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed corners
        send_item(CMD_ADVANCE, '0, '0, '0);                 // nothing running yet
        send_item(CMD_START, '0, '0, '0);                   // zero radius
        send_item(CMD_ADVANCE, center_t'(16383), center_t'(-16384), offset_t'(16383));
        send_item(CMD_START, center_t'(16383), center_t'(16383), offset_t'(16383));
        send_advance();
        send_advance();
        // restart on top of a running circle, opposite corner
        send_item(CMD_START, center_t'(-16384), center_t'(-16384), offset_t'(16383));
        send_advance();
        send_item(CMD_START, center_t'(-1), center_t'(1), offset_t'(1));
        walk_circle(10);
        send_item(CMD_START, center_t'(100), center_t'(-100), offset_t'(5));
        walk_circle(10);
        send_advance();
        send_item(CMD_START, center_t'(16383), center_t'(-16384), offset_t'(2));
        walk_circle(10);
        drain();

        base = productive;
        while (productive - base < RAND_ITEMS) begin
            n = productive - base;
            if (n >= 60) begin
                hold_go = 1'b1;
            end
            if (n >= 127 && tx_idle_pct == 17) begin
                drain();
                tx_idle_pct = 83;
                rx_idle_pct = 17;
            end else if (n >= 254 && tx_idle_pct == 83) begin
                drain();
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                r = rand_radius();
                send_item(CMD_START, rand_center(), rand_center(), r);
                walk_circle((r > 24) ? $urandom_range(1, 4) : 64);
            end else if (kind < 85) begin
                send_item(CMD_START, rand_center(), rand_center(), rand_radius());
                walk_circle($urandom_range(0, 3));
            end else begin
                repeat ($urandom_range(1, 2)) send_advance();
            end
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) begin
            @(posedge aclk);
        end
        repeat (END_PAUSE) @(posedge aclk);
        sb.report_leftovers();

        $display("tb_top: %0d input beats: %0d starts, %0d advances, %0d advances with no circle",
                 beats_in, starts, advances, idle_advances);
        $display("tb_top: %0d circles closed, %0d points compared, %0d mismatches",
                 sb.circles_done, sb.checked, sb.errors);
        if (sb.errors == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
